// ===== sv/ursc_pkg.sv =====
// Shared types, codes and constants for the ultrasonic range and stop controller.
`timescale 1ns / 1ps

package ursc_pkg;

    // Field widths
    localparam int TIMEOUT_W = 16;
    localparam int SETTLE_W  = 8;
    localparam int TRIG_W    = 8;
    localparam int DIST_W    = 18;
    localparam int PULSE_W   = 16;
    localparam int SPEED_W   = 7;
    localparam int CNT_W     = 16;

    // Distance scale: cm in Q8 per microsecond of echo, times 256
    localparam int SCALE_W = 11;
    localparam int PROD_W  = PULSE_W + SCALE_W;
    localparam logic [SCALE_W-1:0] DIST_SCALE = 11'd1124;
    localparam logic [DIST_W-1:0]  DIST_MAX   = 18'h3FFFF;
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd100;

    // Register reset values
    localparam logic [TIMEOUT_W-1:0] RST_ECHO_TIMEOUT = 16'd30000;
    localparam logic [SETTLE_W-1:0]  RST_SETTLE_LOW   = 8'd2;
    localparam logic [TRIG_W-1:0]    RST_TRIG_HIGH    = 8'd10;
    localparam logic [DIST_W-1:0]    RST_CLOSE_THR    = 18'd6400;
    localparam logic [SPEED_W-1:0]   RST_DRIVE_SPEED  = 7'd80;

    // Register indexes on the configuration port
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_ECHO_TIMEOUT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SETTLE_LOW   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TRIG_HIGH    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_CLOSE_THR    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DRIVE_SPEED  = 3'd4;

    // Input operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_TRIG,
        PH_WAITHI,
        PH_MEASURE
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK,
        ST_START_TIMEOUT,
        ST_END_TIMEOUT
    } t_status;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_STOP,
        CMD_RUN
    } t_motor_cmd;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] echo_timeout;
        logic [SETTLE_W-1:0]  settle_low;
        logic [TRIG_W-1:0]    trig_high;
        logic [DIST_W-1:0]    close_thr;
        logic [SPEED_W-1:0]   drive_speed;
    } t_cfg;

    typedef struct packed {
        t_phase           phase;
        logic [CNT_W-1:0] counter;
        logic             running;
    } t_state;

    typedef struct packed {
        logic               running;
        logic [SPEED_W-1:0] speed;
        t_motor_cmd         cmd;
        logic [DIST_W-1:0]  distance;
        logic [PULSE_W-1:0] pulse;
        t_status            status;
        logic               done;
        logic               busy;
        logic               trigger;
    } t_result;

endpackage

// ===== sv/ursc_step.sv =====
// One-item state update: trigger sequencing, echo timing, distance and motor supervision.
`timescale 1ns / 1ps

module ursc_step (
    input  ursc_pkg::t_cfg    i_cfg,
    input  ursc_pkg::t_state  i_state,
    input  logic              i_op,
    input  logic              i_echo,
    output ursc_pkg::t_state  o_state,
    output ursc_pkg::t_result o_res
);
    import ursc_pkg::*;

    t_state              n_state;
    t_result             res;
    logic [CNT_W-1:0]    cnt_inc;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-9:0]   scaled;
    logic [DIST_W-1:0]   dist_sat;
    logic                done;
    t_status             status;
    logic                too_close;

    // Scale the running count into a saturated Q8 distance
    assign cnt_inc = i_state.counter + {{(CNT_W-1){1'b0}}, 1'b1};
    assign prod    = {{SCALE_W{1'b0}}, i_state.counter} * {{PULSE_W{1'b0}}, DIST_SCALE};
    assign scaled  = prod[PROD_W-1:8];
    assign dist_sat = (scaled > {1'b0, DIST_MAX}) ? DIST_MAX : scaled[DIST_W-1:0];

    // Advance the measurement sequence
    always_comb begin
        n_state = i_state;
        done    = 1'b0;
        status  = ST_OK;
        if (i_op == OP_START) begin
            if (i_state.phase == PH_IDLE) begin
                n_state.phase   = (i_cfg.settle_low == '0) ? PH_TRIG : PH_SETTLE;
                n_state.counter = '0;
            end
        end else begin
            unique case (i_state.phase)
                PH_IDLE: begin
                end
                PH_SETTLE: begin
                    n_state.counter = cnt_inc;
                    if (cnt_inc >= {{(CNT_W-SETTLE_W){1'b0}}, i_cfg.settle_low}) begin
                        n_state.phase   = PH_TRIG;
                        n_state.counter = '0;
                    end
                end
                PH_TRIG: begin
                    n_state.counter = cnt_inc;
                    if (cnt_inc >= {{(CNT_W-TRIG_W){1'b0}}, i_cfg.trig_high}) begin
                        n_state.phase   = PH_WAITHI;
                        n_state.counter = '0;
                    end
                end
                PH_WAITHI: begin
                    if (i_echo) begin
                        n_state.phase   = PH_MEASURE;
                        n_state.counter = '0;
                    end else begin
                        n_state.counter = cnt_inc;
                        if (cnt_inc >= i_cfg.echo_timeout) begin
                            done   = 1'b1;
                            status = ST_START_TIMEOUT;
                        end
                    end
                end
                PH_MEASURE: begin
                    if (!i_echo) begin
                        done = 1'b1;
                    end else begin
                        n_state.counter = cnt_inc;
                        if (cnt_inc >= i_cfg.echo_timeout) begin
                            done   = 1'b1;
                            status = ST_END_TIMEOUT;
                        end
                    end
                end
                default: begin
                    n_state.phase   = PH_IDLE;
                    n_state.counter = '0;
                end
            endcase
        end

        // Build the result and run the stop/resume supervisor on completion
        res        = '0;
        res.done   = done;
        res.status = status;
        res.cmd    = CMD_NONE;
        if (done && status == ST_OK) begin
            res.pulse    = i_state.counter;
            res.distance = dist_sat;
        end
        too_close = (status != ST_OK) || (res.distance < i_cfg.close_thr);
        if (done) begin
            n_state.phase   = PH_IDLE;
            n_state.counter = '0;
            if (too_close && i_state.running) begin
                res.cmd         = CMD_STOP;
                n_state.running = 1'b0;
            end else if (!too_close && !i_state.running) begin
                res.cmd         = CMD_RUN;
                res.speed       = (i_cfg.drive_speed > SPEED_MAX) ? SPEED_MAX
                                                                  : i_cfg.drive_speed;
                n_state.running = 1'b1;
            end
        end
        res.trigger = (n_state.phase == PH_TRIG);
        res.busy    = (n_state.phase != PH_IDLE);
        res.running = n_state.running;
    end

    assign o_state = n_state;
    assign o_res   = res;

endmodule

// ===== sv/ultrasonic_range_stop_controller_unit.sv =====
// Top level: stream ports, configuration registers, pipeline registers and supervisor state.
`timescale 1ns / 1ps

// Ultrasonic echo ranger with motor stop/resume supervision. Each input transaction is a
// one-microsecond tick (tuser 0) carrying the sampled echo level, or a start request
// (tuser 1). Every input transaction yields exactly one output transaction with the trigger
// pin level, busy/done flags, and on completion the status, pulse width, Q8 distance and any
// motor command. The block sustains one transaction per clock cycle while the output is not
// stalled: the whole per-item state update is one pass of logic between an input register
// and an output register. Backpressure on the output stalls the input side only once both
// registers are full. Configuration must be written by the user over the APB-style port only
// while no transaction is in flight; the block itself does not enforce this.
module ultrasonic_range_stop_controller_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] echo_level, [7:1] zero
    input  logic [0:0]  i_s_axis_tuser,   // [0] op
    // master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] trigger_level, [1] busy_res, [2] done_res, [4:3] status, [20:5] pulse_us,
    // [38:21] distance_q8, [40:39] motor_cmd, [47:41] motor_speed, [48] motors_running,
    // [55:49] zero
    output logic [55:0] o_m_axis_tdata,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ursc_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_res;
    t_result r_out;
    logic    r_in_valid;
    logic    r_in_op;
    logic    r_in_echo;
    logic    r_out_valid;
    logic    adv;
    logic    cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    // Handshake: advance the input stage whenever the output register can take it
    assign adv             = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {7'b0, r_out};

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.echo_timeout <= RST_ECHO_TIMEOUT;
            r_cfg.settle_low   <= RST_SETTLE_LOW;
            r_cfg.trig_high    <= RST_TRIG_HIGH;
            r_cfg.close_thr    <= RST_CLOSE_THR;
            r_cfg.drive_speed  <= RST_DRIVE_SPEED;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ECHO_TIMEOUT: r_cfg.echo_timeout <= pwdata[TIMEOUT_W-1:0];
                REG_SETTLE_LOW:   r_cfg.settle_low   <= pwdata[SETTLE_W-1:0];
                REG_TRIG_HIGH:    r_cfg.trig_high    <= pwdata[TRIG_W-1:0];
                REG_CLOSE_THR:    r_cfg.close_thr    <= pwdata[DIST_W-1:0];
                REG_DRIVE_SPEED:  r_cfg.drive_speed  <= pwdata[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            REG_ECHO_TIMEOUT: prdata = {{(32-TIMEOUT_W){1'b0}}, r_cfg.echo_timeout};
            REG_SETTLE_LOW:   prdata = {{(32-SETTLE_W){1'b0}}, r_cfg.settle_low};
            REG_TRIG_HIGH:    prdata = {{(32-TRIG_W){1'b0}}, r_cfg.trig_high};
            REG_CLOSE_THR:    prdata = {{(32-DIST_W){1'b0}}, r_cfg.close_thr};
            REG_DRIVE_SPEED:  prdata = {{(32-SPEED_W){1'b0}}, r_cfg.drive_speed};
            default:          prdata = '0;
        endcase
    end

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op   <= i_s_axis_tuser[0];
            r_in_echo <= i_s_axis_tdata[0];
        end
    end

    ursc_step u_step (
        .i_cfg   (r_cfg),
        .i_state (r_state),
        .i_op    (r_in_op),
        .i_echo  (r_in_echo),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // Commit state and result as the item moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase   <= PH_IDLE;
            r_state.counter <= '0;
            r_state.running <= 1'b1;
            r_out_valid     <= 1'b0;
        end else begin
            if (adv) begin
                r_state <= n_state;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_res;
        end
    end

    // A finished measurement leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_res.done |=> r_state.phase == PH_IDLE && r_state.counter == '0)
        else $error("sequencer not idle after a finished measurement");

    // A stop command clears the running flag, a run command sets it
    a_stop_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_res.cmd == CMD_STOP |=> !r_state.running)
        else $error("running flag still set after stop command");

    a_run_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_res.cmd == CMD_RUN |=> r_state.running)
        else $error("running flag clear after run command");

    // Input side stalls only while both pipeline registers are occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid && r_out_valid && !i_m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // Trigger pin in the result matches the phase the item left behind
    a_trig_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out.trigger == (r_state.phase == PH_TRIG))
        else $error("trigger level disagrees with sequencer phase");

endmodule
